/* hdl/sbi_pkg.sv */
// shared types and constants for the signed breakpoint interpolator
package sbi_pkg;

  localparam int unsigned DAMPING_POINTS_N_DEF  = 16;
  localparam int unsigned FRICTION_POINTS_N_DEF = 16;
  localparam longint unsigned VEL_SPAN          = 64'd1000000;

  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;
  localparam logic SEL_DAMPING = 1'b0;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic        [30:0] vel;
    logic signed [31:0] val;
  } sbi_entry_t;

endpackage

/* hdl/sbi_cell.sv */
// one breakpoint cell of a rotating table chain
`default_nettype none
module sbi_cell #(
  parameter logic [30:0] RST_VEL = 31'd0
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  shift,
  input  sbi_pkg::sbi_entry_t  nb_ent,
  input  wire                  wr,
  input  sbi_pkg::sbi_entry_t  wr_ent,
  output sbi_pkg::sbi_entry_t  ent
);
  import sbi_pkg::*;

  sbi_entry_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vel <= RST_VEL;
      ent_r.val <= '0;
    end else if (shift) begin
      ent_r <= nb_ent;
    end else if (wr) begin
      ent_r <= wr_ent;
    end
  end

  assign ent = ent_r;
endmodule
`default_nettype wire

/* hdl/sbi_divider.sv */
// unsigned restoring divider, 64 by 32 bits, one quotient bit per cycle
`default_nettype none
module sbi_divider (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [63:0] dividend,
  input  wire  [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import sbi_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] dsr_r;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], dvd_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = trial - {1'b0, dsr_r};
        dvd_nxt = {dvd_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        dvd_nxt = {dvd_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    if (start) dsr_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = dvd_r;
endmodule
`default_nettype wire

/* hdl/signed_breakpoint_interpolator.sv */
// Top level of the signed breakpoint interpolator.
// A load beat writes its cell and leaves the block idle. A lookup passes through the check,
// the chain rotation, the product and divider start, the divider wait, the fold and the
// output state, which holds while the output is stalled. At or above the last breakpoint a
// lookup goes from the check straight to output, a flat segment from the product state.
// One item at a time; reset restores the evenly spaced breakpoints and zero values.
`default_nettype none
module signed_breakpoint_interpolator #(
  parameter int unsigned DAMPING_POINTS_N  = sbi_pkg::DAMPING_POINTS_N_DEF,
  parameter int unsigned FRICTION_POINTS_N = sbi_pkg::FRICTION_POINTS_N_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // entry_index, entry_velocity, entry_value, velocity, zero fill
  input  wire  [sbi_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind, table_select
  input  wire  [sbi_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // compensation
  output logic [sbi_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import sbi_pkg::*;

  localparam int unsigned MAXN = (DAMPING_POINTS_N > FRICTION_POINTS_N) ?
                                 DAMPING_POINTS_N : FRICTION_POINTS_N;
  localparam int unsigned CW   = $clog2(MAXN + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DSTRT = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  // input fields
  logic               kind, table_select;
  logic [3:0]         entry_index;
  logic [30:0]        entry_velocity;
  logic signed [31:0] entry_value, velocity;

  assign kind           = in_tuser[0];
  assign table_select   = in_tuser[1];
  assign entry_index    = in_tdata[3:0];
  assign entry_velocity = in_tdata[34:4];
  assign entry_value    = in_tdata[66:35];
  assign velocity       = in_tdata[98:67];

  logic [2:0]           state_r, state_nxt;
  logic                 sel_r;
  logic [30:0]          mag_r;
  logic                 vzero_r, vneg_r;
  logic [CW-1:0]        step_r, step_nxt;
  logic                 found_r, found_nxt;
  logic [30:0]          x0_r, x1_r;
  logic signed [31:0]   y0_r, y1_r;
  logic signed [64:0]   prod_r;
  logic                 qneg_r;
  logic signed [31:0]   res_r;
  logic                 out_tvalid_r;
  logic [31:0]          out_data_r;

  logic                 in_acc, load_acc;
  sbi_entry_t           wr_ent;
  sbi_entry_t           d_ent [DAMPING_POINTS_N];
  sbi_entry_t           f_ent [FRICTION_POINTS_N];
  logic                 d_shift, f_shift;
  sbi_entry_t           c0, c1, clast;
  logic [CW-1:0]        n_sel;

  logic                 div_start, div_done;
  logic [63:0]          div_dvd, div_q;
  logic [31:0]          div_dsr;
  logic signed [31:0]   dx;
  logic signed [32:0]   dy;
  logic signed [31:0]   dm;
  logic signed [65:0]   qs, sum;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (kind == KIND_LOAD);
  assign wr_ent.vel = entry_velocity;
  assign wr_ent.val = entry_value;

  assign d_shift = (state_r == ST_SCAN) && (sel_r == SEL_DAMPING);
  assign f_shift = (state_r == ST_SCAN) && (sel_r != SEL_DAMPING);

  // damping chain, rotates toward cell 0
  for (genvar k = 0; k < DAMPING_POINTS_N; k++) begin : g_dcell
    localparam logic [30:0] RV =
      31'((64'(k) * VEL_SPAN) / 64'(DAMPING_POINTS_N - 1));
    sbi_cell #(.RST_VEL(RV)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .shift  (d_shift),
      .nb_ent (d_ent[(k + 1) % DAMPING_POINTS_N]),
      .wr     (load_acc && (table_select == SEL_DAMPING) &&
               (32'(entry_index) == 32'(k))),
      .wr_ent (wr_ent),
      .ent    (d_ent[k])
    );
  end

  // friction chain
  for (genvar k = 0; k < FRICTION_POINTS_N; k++) begin : g_fcell
    localparam logic [30:0] RV =
      31'((64'(k) * VEL_SPAN) / 64'(FRICTION_POINTS_N - 1));
    sbi_cell #(.RST_VEL(RV)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .shift  (f_shift),
      .nb_ent (f_ent[(k + 1) % FRICTION_POINTS_N]),
      .wr     (load_acc && (table_select != SEL_DAMPING) &&
               (32'(entry_index) == 32'(k))),
      .wr_ent (wr_ent),
      .ent    (f_ent[k])
    );
  end

  assign c0    = (sel_r == SEL_DAMPING) ? d_ent[0] : f_ent[0];
  assign c1    = (sel_r == SEL_DAMPING) ? d_ent[1] : f_ent[1];
  assign clast = (sel_r == SEL_DAMPING) ? d_ent[DAMPING_POINTS_N-1]
                                        : f_ent[FRICTION_POINTS_N-1];
  assign n_sel = (sel_r == SEL_DAMPING) ? CW'(DAMPING_POINTS_N) : CW'(FRICTION_POINTS_N);

  assign dy = 33'(y1_r) - 33'(y0_r);
  assign dm = $signed({1'b0, mag_r}) - $signed({1'b0, x0_r});
  assign dx = $signed({1'b0, x1_r}) - $signed({1'b0, x0_r});

  assign div_start = (state_r == ST_DSTRT);
  assign div_dvd   = prod_r[64] ? 64'(-prod_r) : prod_r[63:0];
  assign div_dsr   = dx[31] ? 32'(-dx) : 32'(dx);

  assign qs  = qneg_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign sum = 66'(y0_r) + qs;

  sbi_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    found_nxt = found_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (kind == KIND_LOOKUP)) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        step_nxt  = '0;
        found_nxt = 1'b0;
        state_nxt = (mag_r >= clast.vel) ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        if (!found_r && (step_r < n_sel - CW'(1)) && (mag_r <= c1.vel)) found_nxt = 1'b1;
        step_nxt = step_r + CW'(1);
        if (step_r == n_sel - CW'(1)) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = (x1_r == x0_r) ? ST_OUT : ST_DSTRT;
      end
      ST_DSTRT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) state_nxt = ST_FIN;
      end
      ST_FIN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      found_r <= found_nxt;
      if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sel_r   <= table_select;
      vzero_r <= (velocity == 32'sd0);
      vneg_r  <= velocity[31];
      if (velocity == S32_MIN) mag_r <= 31'h7fffffff;
      else                     mag_r <= velocity[31] ? 31'(-velocity) : velocity[30:0];
    end
    if (state_r == ST_CHECK) res_r <= clast.val;
    if (state_r == ST_SCAN && !found_r && (step_r < n_sel - CW'(1)) &&
        (mag_r <= c1.vel)) begin
      x0_r <= c0.vel;
      y0_r <= c0.val;
      x1_r <= c1.vel;
      y1_r <= c1.val;
    end
    if (state_r == ST_MUL) begin
      prod_r <= 65'(dy) * 65'(dm);
      qneg_r <= ((dy < 0) != (dm < 0)) ^ dx[31];
      res_r  <= y0_r;
    end
    if (state_r == ST_FIN) begin
      if (sum > 66'(S32_MAX))      res_r <= S32_MAX;
      else if (sum < 66'(S32_MIN)) res_r <= S32_MIN;
      else                         res_r <= sum[31:0];
    end
    if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
      if (vzero_r)                      out_data_r <= '0;
      else if (!vneg_r)                 out_data_r <= res_r;
      else if (res_r == S32_MIN)        out_data_r <= S32_MAX;
      else                              out_data_r <= 32'(-res_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // the rotation never runs past one full turn
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (step_r < n_sel))
    else $error("scan step past table length");

  // a segment is always found once the last breakpoint exceeds the magnitude
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> found_r)
    else $error("no segment found");

  // divider finishes only while waited on
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("unexpected divider completion");

  // chains sit still outside the scan so loads land at their index
  a_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |-> !(d_shift || f_shift))
    else $error("load during rotation");
endmodule
`default_nettype wire

/* verif/testbench.sv */
// testbench for the signed breakpoint interpolator: directed and random loads and lookups
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbi_pkg::*;

  localparam int unsigned NPTS = 16;
  localparam int unsigned WATCHDOG_CYCLES = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  signed_breakpoint_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of both tables, index 0 damping, 1 friction
  logic [30:0] bp_vel [2][NPTS];
  logic signed [31:0] bp_val [2][NPTS];
  logic signed [31:0] comp_queue [$];
  int mismatches = 0;
  int n_loads = 0;
  int n_lookups = 0;
  int n_results = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit timed_out = 1'b0;

  function automatic longint sat32(longint v);
    if (v > longint'(S32_MAX)) return longint'(S32_MAX);
    if (v < longint'(S32_MIN)) return longint'(S32_MIN);
    return v;
  endfunction

  function automatic logic signed [31:0] interpolate(bit sel, logic signed [31:0] vel);
    longint mag, x0, x1, y0, y1, r;
    bit found;
    mag = vel;
    if (mag < 0) mag = -mag;
    if (mag > longint'(S32_MAX)) mag = longint'(S32_MAX);
    r = 0;
    found = 1'b0;
    if (mag >= longint'(bp_vel[sel][NPTS-1])) begin
      r = bp_val[sel][NPTS-1];
    end else begin
      for (int i = 1; i < NPTS; i++) begin
        if (!found && mag <= longint'(bp_vel[sel][i])) begin
          found = 1'b1;
          x0 = bp_vel[sel][i-1];
          x1 = bp_vel[sel][i];
          y0 = bp_val[sel][i-1];
          y1 = bp_val[sel][i];
          if (x1 == x0) r = y0;
          else r = sat32(y0 + ((y1 - y0) * (mag - x0)) / (x1 - x0));
        end
      end
    end
    if (vel == 0) r = 0;
    else if (vel < 0) r = sat32(-r);
    return r[31:0];
  endfunction

  // one beat on the input channel, predicting as it is accepted
  task automatic send_item(logic kind, bit sel, logic [3:0] idx, logic [30:0] ev,
                           logic signed [31:0] eval, logic signed [31:0] vel);
    while (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {sel, kind};
    in_tdata <= {5'd0, vel, eval, ev, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == KIND_LOAD) begin
      bp_vel[sel][idx] = ev;
      bp_val[sel][idx] = eval;
      n_loads++;
    end else begin
      comp_queue.push_back(interpolate(sel, vel));
      n_lookups++;
    end
  endtask

  task automatic lookup(bit sel, logic signed [31:0] vel);
    send_item(KIND_LOOKUP, sel, 4'($urandom), 31'($urandom), $urandom, vel);
  endtask

  task automatic load(bit sel, logic [3:0] idx, logic [30:0] ev, logic signed [31:0] eval);
    send_item(KIND_LOAD, sel, idx, ev, eval, $urandom);
  endtask

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(0, 2100000);
      2: return -$signed($urandom_range(0, 2100000));
      3: return $urandom_range(0, 3) == 0 ? S32_MIN : S32_MAX - $urandom_range(3);
      default: return $signed($urandom_range(0, 1100000)) * ($urandom_range(1) ? 1 : -1);
    endcase
  endfunction

  task automatic test_reset_tables();
    lookup(0, 0);
    lookup(0, 500000);
    lookup(1, -700000);
    lookup(1, S32_MIN);
    lookup(0, S32_MAX);
  endtask

  task automatic test_directed_loads();
    // extreme values and a flat segment
    load(0, 0, 31'd0, S32_MIN);
    load(0, 1, 31'd1000, S32_MAX);
    load(0, 2, 31'd1000, 32'sd5);
    load(0, 15, 31'h7fffffff, S32_MAX);
    lookup(0, 1);
    lookup(0, -999);
    lookup(0, 1000);
    lookup(0, 1500);
    lookup(0, S32_MIN);
    lookup(0, S32_MAX);
    // unsorted friction table
    load(1, 3, 31'd10, -32'sd100000);
    load(1, 4, 31'd5, 32'sd7);
    load(1, 15, 31'd1, 32'sd33);
    lookup(1, 3);
    lookup(1, -8);
    lookup(1, 2000);
  endtask

  task automatic test_random(int items);
    for (int k = 0; k < items; k++) begin
      calm = (k >= items / 3 && k < items / 2);
      if ($urandom_range(9) < 2) begin
        load(1'($urandom_range(1)), 4'($urandom),
             31'($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 1200000)),
             $urandom_range(1) ? $urandom : $signed($urandom_range(0, 2000)) - 1000);
      end else if ($urandom_range(29) == 0) begin
        // rebuild a sorted table with random content
        bit sel;
        logic [30:0] v;
        sel = 1'($urandom_range(1));
        v = 31'($urandom_range(0, 1000));
        for (int i = 0; i < NPTS; i++) begin
          load(sel, 4'(i), v,
               $urandom_range(1) ? $urandom : $signed($urandom_range(0, 200000)) - 100000);
          v = 31'(v + $urandom_range(0, 150000));
        end
        k = k + int'(NPTS) - 1;
      end else begin
        lookup(1'($urandom_range(1)), rand_vel());
      end
    end
    calm = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= calm || $urandom_range(99) >= 8;
      if (out_tvalid && out_tready) begin
        n_results++;
        if (comp_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d", $signed(out_tdata));
        end else begin
          logic signed [31:0] exp_comp;
          exp_comp = comp_queue.pop_front();
          if (out_tdata !== exp_comp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("compensation mismatch: expected %0d got %0d", exp_comp,
                       $signed(out_tdata));
          end
        end
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_CYCLES && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired");
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < NPTS; i++) begin
        bp_vel[t][i] = 31'((i * 1000000) / (NPTS - 1));
        bp_val[t][i] = 0;
      end
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_tables();
    test_directed_loads();
    test_random(1300);
    in_tvalid <= 1'b0;
    while (comp_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d loads and %0d lookups, %0d results checked",
             n_loads, n_lookups, n_results);
    if (mismatches == 0 && comp_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, comp_queue.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
